// ===== sv/delimiter_split_tokenizer_unit_defines.svh =====
// assertion macros shared by the tokenizer rtl
`ifndef DELIMITER_SPLIT_TOKENIZER_UNIT_DEFINES_SVH
`define DELIMITER_SPLIT_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define DST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DST_ASSERT(lbl, prop)
`define DST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/dst_pkg.sv =====
// shared types and constants of the delimiter split tokenizer
package dst_pkg;

  localparam int SEP_BYTES_W = 64;
  localparam int SEP_LEN_W   = 4;
  localparam int LIMIT_W     = 16;
  localparam int OUT_W       = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIECE_LIMIT      = 2'd2;

  localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RESET = 64'd44;
  localparam logic [SEP_LEN_W-1:0]   SEP_LEN_RESET   = 4'd1;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_SPLIT,
    EV_MATCH,
    EV_TAIL,
    EV_EMPTY
  } dst_kind_t;

  typedef struct packed {
    dst_kind_t            kind;
    logic                 fin;
    logic                 last;
    logic [SEP_LEN_W-1:0] sl;
  } dst_entry_t;

endpackage

// ===== sv/dst_front.sv =====
// front end: separator window match, piece limit and event classification
`include "delimiter_split_tokenizer_unit_defines.svh"

module dst_front #(
  parameter int MAX_SEPARATOR_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic [7:0]                       text_byte,
  input  logic                             last_byte,
  input  logic                             empty_string,
  input  logic [dst_pkg::SEP_BYTES_W-1:0]  sep_bytes,
  input  logic [dst_pkg::SEP_LEN_W-1:0]    sep_len,
  input  logic [dst_pkg::LIMIT_W-1:0]      piece_limit,
  output dst_pkg::dst_entry_t              entry
);

  localparam int WIN_W = 8 * MAX_SEPARATOR_BYTES;
  localparam int BIP_W = $clog2(MAX_SEPARATOR_BYTES + 1);
  localparam int SEL_W = (MAX_SEPARATOR_BYTES > 1) ? $clog2(MAX_SEPARATOR_BYTES) : 1;
  localparam logic [dst_pkg::SEP_LEN_W-1:0] SL_MAX = dst_pkg::SEP_LEN_W'(MAX_SEPARATOR_BYTES);
  localparam logic [BIP_W-1:0] BIP_MAX = BIP_W'(MAX_SEPARATOR_BYTES);

  logic [WIN_W-1:0]                 recent;
  logic [WIN_W+7:0]                 shifted;
  logic [WIN_W-1:0]                 recent_next;
  logic [BIP_W-1:0]                 bip;
  logic [BIP_W-1:0]                 bip_inc;
  logic [dst_pkg::LIMIT_W-1:0]      cnt;
  logic [dst_pkg::LIMIT_W-1:0]      cnt_inc;
  logic                             limit_reached;
  logic [dst_pkg::SEP_LEN_W-1:0]    sl_eff;
  logic                             win_ok;
  logic                             match;
  logic                             hit;
  logic                             counted;

  assign sl_eff      = (sep_len > SL_MAX) ? SL_MAX : sep_len;
  assign shifted     = {recent, text_byte};
  assign recent_next = shifted[WIN_W-1:0];
  assign bip_inc     = (bip < BIP_MAX) ? bip + BIP_W'(1) : bip;
  assign cnt_inc     = (cnt != '1) ? cnt + dst_pkg::LIMIT_W'(1) : cnt;
  assign hit         = (piece_limit != '0) && (cnt_inc >= piece_limit);

  always_comb begin
    logic [SEL_W-1:0] sel;
    win_ok = 1'b1;
    sel    = '0;
    for (int k = 0; k < MAX_SEPARATOR_BYTES; k++) begin
      if (dst_pkg::SEP_LEN_W'(k) < sl_eff) begin
        sel = SEL_W'(sl_eff - dst_pkg::SEP_LEN_W'(k) - dst_pkg::SEP_LEN_W'(1));
        if (recent_next[8*k +: 8] != sep_bytes[8*sel +: 8]) begin
          win_ok = 1'b0;
        end
      end
    end
  end

  assign match = (sl_eff != '0) && (dst_pkg::SEP_LEN_W'(bip_inc) >= sl_eff) && win_ok;

  always_comb begin
    entry.kind = dst_pkg::EV_NONE;
    entry.fin  = 1'b0;
    entry.last = last_byte;
    entry.sl   = sl_eff;
    counted    = 1'b0;
    priority if (empty_string) begin
      entry.kind = dst_pkg::EV_EMPTY;
      entry.fin  = 1'b1;
    end else if (limit_reached) begin
      entry.kind = dst_pkg::EV_NONE;
    end else if (sl_eff == '0) begin
      entry.kind = dst_pkg::EV_SPLIT;
      entry.fin  = last_byte || hit;
      counted    = 1'b1;
    end else if (match) begin
      entry.kind = dst_pkg::EV_MATCH;
      entry.fin  = last_byte || hit;
      counted    = 1'b1;
    end else if (last_byte) begin
      entry.kind = dst_pkg::EV_TAIL;
      entry.fin  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent        <= '0;
      bip           <= '0;
      cnt           <= '0;
      limit_reached <= 1'b0;
    end else if (take) begin
      if (empty_string || last_byte) begin
        recent        <= '0;
        bip           <= '0;
        cnt           <= '0;
        limit_reached <= 1'b0;
      end else begin
        recent <= recent_next;
        bip    <= (entry.kind == dst_pkg::EV_MATCH) ? '0 : bip_inc;
        if (counted) begin
          cnt           <= cnt_inc;
          limit_reached <= hit;
        end
      end
    end
  end

  `DST_ASSERT(a_limit_quiet, (take && limit_reached && !empty_string) |-> (entry.kind == dst_pkg::EV_NONE))

endmodule

// ===== sv/dst_fifo.sv =====
// short event queue between front and back end
`include "delimiter_split_tokenizer_unit_defines.svh"

module dst_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dst_pkg::dst_entry_t wr_entry,
  input  logic                pop,
  output dst_pkg::dst_entry_t rd_entry,
  output logic                full,
  output logic                empty
);

  dst_pkg::dst_entry_t             store [dst_pkg::QUEUE_DEPTH];
  logic [dst_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [dst_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [dst_pkg::QUEUE_PTR_W:0]   count;

  assign full     = (count == (dst_pkg::QUEUE_PTR_W + 1)'(dst_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dst_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dst_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (dst_pkg::QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (dst_pkg::QUEUE_PTR_W + 1)'(1);
      end
    end
  end

  `DST_ASSERT(a_no_pop_empty, pop |-> !empty)
  `DST_ASSERT(a_no_push_full, push |-> !full)

endmodule

// ===== sv/dst_back.sv =====
// back end: byte offsets, piece start and length, output register
`include "delimiter_split_tokenizer_unit_defines.svh"

module dst_back #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        avail,
  input  dst_pkg::dst_entry_t         entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dst_pkg::OUT_W-1:0]   piece_start,
  output logic [dst_pkg::OUT_W-1:0]   piece_length,
  output logic                        final_piece,
  output logic                        overflow
);

  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;

  function automatic logic [dst_pkg::OUT_W-1:0] to_out(input logic [OFFSET_WIDTH-1:0] v);
    logic [OFFSET_WIDTH+dst_pkg::OUT_W-1:0] w;
    w = {{dst_pkg::OUT_W{1'b0}}, v};
    return w[dst_pkg::OUT_W-1:0];
  endfunction

  logic [OFFSET_WIDTH-1:0] pos;
  logic [OFFSET_WIDTH-1:0] cps;
  logic                    sat;
  logic [OFFSET_WIDTH-1:0] end_pos;
  logic                    sat_n;
  logic [OFFSET_WIDTH-1:0] sl_ext;
  logic [OFFSET_WIDTH-1:0] ms;
  logic [OFFSET_WIDTH-1:0] mlen;
  logic [OFFSET_WIDTH-1:0] tlen;
  logic                    emit;
  logic [OFFSET_WIDTH-1:0] res_start;
  logic [OFFSET_WIDTH-1:0] res_len;
  logic                    res_fin;
  logic                    res_ovf;

  assign pop     = avail && (!out_valid || out_ready);
  assign end_pos = (pos == OFS_MAX) ? pos : pos + OFFSET_WIDTH'(1);
  assign sat_n   = sat || (pos == OFS_MAX);
  assign sl_ext  = OFFSET_WIDTH'(entry.sl);
  assign ms      = (end_pos >= sl_ext) ? end_pos - sl_ext : '0;
  assign mlen    = (ms >= cps) ? ms - cps : '0;
  assign tlen    = (end_pos >= cps) ? end_pos - cps : '0;

  always_comb begin
    emit      = 1'b0;
    res_start = '0;
    res_len   = '0;
    res_fin   = entry.fin;
    res_ovf   = sat_n;
    unique case (entry.kind)
      dst_pkg::EV_EMPTY: begin
        emit    = 1'b1;
        res_fin = 1'b1;
        res_ovf = 1'b0;
      end
      dst_pkg::EV_SPLIT: begin
        emit      = 1'b1;
        res_start = pos;
        res_len   = OFFSET_WIDTH'(1);
      end
      dst_pkg::EV_MATCH: begin
        emit      = 1'b1;
        res_start = cps;
        res_len   = mlen;
      end
      dst_pkg::EV_TAIL: begin
        emit      = 1'b1;
        res_start = cps;
        res_len   = tlen;
        res_fin   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      cps       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if ((entry.kind == dst_pkg::EV_EMPTY) || entry.last) begin
          pos <= '0;
          cps <= '0;
          sat <= 1'b0;
        end else begin
          pos <= end_pos;
          sat <= sat_n;
          if (entry.kind == dst_pkg::EV_MATCH) begin
            cps <= end_pos;
          end
        end
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      piece_start  <= to_out(res_start);
      piece_length <= to_out(res_len);
      final_piece  <= res_fin;
      overflow     <= res_ovf;
    end
  end

  `DST_ASSERT_NEXT(a_empty_result, pop && (entry.kind == dst_pkg::EV_EMPTY), out_valid && final_piece && (piece_length == '0))

endmodule

// ===== sv/delimiter_split_tokenizer_unit.sv =====
// top level of the delimiter split tokenizer: config registers and front/queue/back
//
// usage
//   input channel (in_valid/in_ready): one string byte per transfer, last_byte on
//   the final byte, empty_string for a string with no bytes
//   output channel (out_valid/out_ready): one piece per transfer with start offset,
//   length, final_piece and overflow
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 separator
//   bytes, 1 separator length, 2 piece limit; always ready, write only while idle
// path: each result passes through the event queue and then the output register
// throughput: one byte per cycle while in_ready is high, set by the combinational separator
//   window compare in the front end and the offset update in the back end
// reset: config returns to separator "," length 1, no limit; queue and state clear
// receiver stall: results wait in the output register, the four-entry queue absorbs
//   further bytes, and in_ready drops once the queue is full
module delimiter_split_tokenizer_unit #(
  parameter int MAX_SEPARATOR_BYTES = 8,
  parameter int OFFSET_WIDTH        = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        text_byte,
  input  logic                              last_byte,
  input  logic                              empty_string,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dst_pkg::OUT_W-1:0]         piece_start,
  output logic [dst_pkg::OUT_W-1:0]         piece_length,
  output logic                              final_piece,
  output logic                              overflow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dst_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dst_pkg::SEP_BYTES_W-1:0]   cfg_data
);

  logic [dst_pkg::SEP_BYTES_W-1:0] separator_bytes;
  logic [dst_pkg::SEP_LEN_W-1:0]   separator_length;
  logic [dst_pkg::LIMIT_W-1:0]     piece_limit;

  logic                take;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  dst_pkg::dst_entry_t wr_entry;
  dst_pkg::dst_entry_t rd_entry;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_bytes  <= dst_pkg::SEP_BYTES_RESET;
      separator_length <= dst_pkg::SEP_LEN_RESET;
      piece_limit      <= dst_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dst_pkg::CFG_SEPARATOR_BYTES: begin
          separator_bytes <= cfg_data;
        end
        dst_pkg::CFG_SEPARATOR_LENGTH: begin
          separator_length <= cfg_data[dst_pkg::SEP_LEN_W-1:0];
        end
        dst_pkg::CFG_PIECE_LIMIT: begin
          piece_limit <= cfg_data[dst_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  dst_front #(
    .MAX_SEPARATOR_BYTES(MAX_SEPARATOR_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .empty_string (empty_string),
    .sep_bytes    (separator_bytes),
    .sep_len      (separator_length),
    .piece_limit  (piece_limit),
    .entry        (wr_entry)
  );

  dst_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  dst_back #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (!q_empty),
    .entry        (rd_entry),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .piece_start  (piece_start),
    .piece_length (piece_length),
    .final_piece  (final_piece),
    .overflow     (overflow)
  );

endmodule

// ===== sim/split_piece_checker.sv =====
// predictor and result checker for the delimiter split tokenizer
`timescale 1ns / 1ps
module split_piece_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      text_byte,
  input  logic                            last_byte,
  input  logic                            empty_string,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [dst_pkg::OUT_W-1:0]       piece_start,
  input  logic [dst_pkg::OUT_W-1:0]       piece_length,
  input  logic                            final_piece,
  input  logic                            overflow,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dst_pkg::SEP_BYTES_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_results
);

  localparam int MAX_SEP = 8;
  localparam int unsigned OFFSET_MAX = 65535;

  typedef struct packed {
    logic [dst_pkg::OUT_W-1:0] ofs;
    logic [dst_pkg::OUT_W-1:0] len;
    logic                      fin;
    logic                      ovf;
  } piece_t;

  logic [dst_pkg::SEP_BYTES_W-1:0] sep_bytes;
  logic [dst_pkg::SEP_LEN_W-1:0]   sep_len;
  logic [dst_pkg::LIMIT_W-1:0]     piece_limit;

  logic [63:0] recent;
  int unsigned byte_pos;
  int unsigned piece_begin;
  int          fill;
  int unsigned pieces;
  bit          limit_hit;
  bit          saturated;

  piece_t expected_pieces[$];

  function automatic void clear_string();
    recent = '0;
    byte_pos = 0;
    piece_begin = 0;
    fill = 0;
    pieces = 0;
    limit_hit = 1'b0;
    saturated = 1'b0;
  endfunction

  function automatic bit window_hit(input int sl);
    for (int k = 0; k < sl; k++)
      if (recent[8*k +: 8] != sep_bytes[8*(sl-1-k) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit count_piece();
    if (pieces < 32'hFFFF) pieces++;
    if (piece_limit != 0 && pieces >= 32'(piece_limit)) begin
      limit_hit = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic piece_t make_piece(input int unsigned ofs, input int unsigned len,
                                        input bit fin);
    piece_t pc;
    pc.ofs = ofs[dst_pkg::OUT_W-1:0];
    pc.len = len[dst_pkg::OUT_W-1:0];
    pc.fin = fin;
    pc.ovf = saturated;
    return pc;
  endfunction

  // advances the string state by one transfer, returns 1 when a piece comes out
  function automatic bit split_byte(input logic [7:0] b, input logic lst, input logic emp,
                                    output piece_t pc);
    int          sl;
    int unsigned idx;
    int unsigned stop;
    int unsigned ms;
    int unsigned len;
    bit          hit;
    bit          got;
    got = 1'b0;
    pc = '0;
    if (emp) begin
      clear_string();
      pc = make_piece(0, 0, 1'b1);
      return 1'b1;
    end
    sl = (sep_len > MAX_SEP) ? MAX_SEP : int'(sep_len);
    idx = byte_pos;
    stop = idx + 1;
    if (stop > OFFSET_MAX) begin
      stop = OFFSET_MAX;
      saturated = 1'b1;
    end
    byte_pos = stop;
    recent = {recent[55:0], b};
    if (fill < 8) fill++;
    if (!limit_hit) begin
      if (sl == 0) begin
        hit = count_piece();
        pc = make_piece(idx, 1, lst || hit);
        got = 1'b1;
      end else if (fill >= sl && window_hit(sl)) begin
        ms = (stop >= sl) ? stop - sl : 0;
        len = (ms >= piece_begin) ? ms - piece_begin : 0;
        hit = count_piece();
        pc = make_piece(piece_begin, len, lst || hit);
        got = 1'b1;
        piece_begin = stop;
        fill = 0;
      end else if (lst) begin
        len = (stop >= piece_begin) ? stop - piece_begin : 0;
        pc = make_piece(piece_begin, len, 1'b1);
        got = 1'b1;
      end
    end
    if (lst) clear_string();
    return got;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    piece_t want;
    piece_t pc;
    if (rst) begin
      sep_bytes = dst_pkg::SEP_BYTES_RESET;
      sep_len = dst_pkg::SEP_LEN_RESET;
      piece_limit = dst_pkg::LIMIT_RESET;
      clear_string();
      expected_pieces.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pieces.size() == 0) begin
          $error("unexpected piece: start %0d, length %0d", piece_start, piece_length);
          fail_count++;
        end else begin
          want = expected_pieces.pop_front();
          check_field("piece_start", 32'(want.ofs), 32'(piece_start));
          check_field("piece_length", 32'(want.len), 32'(piece_length));
          check_field("final_piece", 32'(want.fin), 32'(final_piece));
          check_field("overflow", 32'(want.ovf), 32'(overflow));
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dst_pkg::CFG_SEPARATOR_BYTES:  sep_bytes = cfg_data;
          dst_pkg::CFG_SEPARATOR_LENGTH: sep_len = cfg_data[dst_pkg::SEP_LEN_W-1:0];
          dst_pkg::CFG_PIECE_LIMIT:      piece_limit = cfg_data[dst_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (split_byte(text_byte, last_byte, empty_string, pc)) expected_pieces.push_back(pc);
      end
    end
    pending_results = expected_pieces.size();
  end

endmodule

// ===== sim/delimiter_split_tokenizer_unit_test.sv =====
// testbench top for the delimiter split tokenizer: stimulus, receiver and verdict
`timescale 1ns / 1ps
module delimiter_split_tokenizer_unit_test;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TOTAL_ITEMS = 400;
  localparam logic [dst_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] COMMA = 8'd44;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      text_byte = 8'd0;
  logic                            last_byte = 1'b0;
  logic                            empty_string = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [dst_pkg::OUT_W-1:0]       piece_start;
  logic [dst_pkg::OUT_W-1:0]       piece_length;
  logic                            final_piece;
  logic                            overflow;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dst_pkg::CFG_INDEX_W-1:0] cfg_index = dst_pkg::CFG_SEPARATOR_BYTES;
  logic [dst_pkg::SEP_BYTES_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_results;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_receiver = 1'b0;

  always #10 clk = ~clk;

  delimiter_split_tokenizer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .last_byte(last_byte), .empty_string(empty_string),
    .out_valid(out_valid), .out_ready(out_ready),
    .piece_start(piece_start), .piece_length(piece_length),
    .final_piece(final_piece), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  split_piece_checker piece_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .last_byte(last_byte), .empty_string(empty_string),
    .out_valid(out_valid), .out_ready(out_ready),
    .piece_start(piece_start), .piece_length(piece_length),
    .final_piece(final_piece), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  task automatic send_item(input logic [7:0] b, input logic lst, input logic emp);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    last_byte <= lst;
    empty_string <= emp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [63:0] sep, input logic [3:0] sl,
                              input logic [15:0] lim, input bit poke_unused);
    logic [dst_pkg::CFG_INDEX_W-1:0] idx [4];
    logic [63:0]                     val [4];
    int                              n;
    idx = '{dst_pkg::CFG_SEPARATOR_BYTES, dst_pkg::CFG_SEPARATOR_LENGTH,
            dst_pkg::CFG_PIECE_LIMIT, CFG_UNUSED};
    val[0] = sep;
    val[1] = {$urandom(), 28'($urandom()), sl};
    val[2] = {16'($urandom()), $urandom(), lim};
    val[3] = {$urandom(), $urandom()};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // separator runs, broken separators and loose bytes, sometimes abandoned midway or replaced by an empty string
  task automatic send_random_string(input logic [63:0] sep, input int sl);
    logic [7:0] text [$];
    int         target;
    int         cut;
    int         abandon_at;
    if ($urandom_range(0, 9) == 0) begin
      send_item(8'($urandom()), 1'($urandom()), 1'b1);
      return;
    end
    target = $urandom_range(1, 14);
    while (text.size() < target) begin
      case ($urandom_range(0, 5))
        0, 1: for (int k = 0; k < sl; k++) text.push_back(sep[8*k +: 8]);
        2: begin
          cut = $urandom_range(0, sl);
          for (int k = 0; k < cut; k++) text.push_back(sep[8*k +: 8]);
        end
        3: text.push_back(sl > 0 ? sep[8*$urandom_range(0, sl-1) +: 8] : 8'($urandom()));
        default: text.push_back(8'($urandom()));
      endcase
    end
    abandon_at = ($urandom_range(0, 14) == 0) ? $urandom_range(1, text.size()) : -1;
    for (int i = 0; i < text.size(); i++) begin
      if (i == abandon_at) begin
        send_item(8'($urandom()), 1'($urandom()), 1'b1);
        return;
      end
      send_item(text[i], i == text.size() - 1, 1'b0);
    end
  endtask

  // receiver: per-transfer stalls, calm stretches and one long hold-off
  initial begin
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_receiver = 1'b0;
      end else begin
        stall = (rx_steady || calm) ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] sep;
    logic [3:0]  sl_cfg;
    logic [15:0] lim;
    int          sl_used;
    int          phase_end;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset config: comma separator, no limit
    send_item(8'h78, 1'b0, 1'b0);
    send_item(COMMA, 1'b0, 1'b0);
    send_item(8'h79, 1'b1, 1'b0);
    send_item(COMMA, 1'b0, 1'b0);
    send_item(COMMA, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h71, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    wait_drained();

    // widest separator
    sep = 64'hF00D_CAFE_1234_5A5A;
    write_config(sep, 4'd8, 16'd0, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    for (int k = 0; k < 8; k++) send_item(sep[8*k +: 8], 1'b0, 1'b0);
    send_item(8'h7A, 1'b1, 1'b0);
    wait_drained();

    // per-byte split cut off by the limit
    write_config(64'd44, 4'd0, 16'd2, 1'b1);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h0F, 1'b1, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    write_config(64'd44, 4'd0, 16'd0, 1'b0);
    hold_receiver = 1'b1;
    tx_steady = 1'b1;
    for (int i = 0; i < 40; i++) send_item(8'($urandom()), i == 39, 1'b0);
    tx_steady = 1'b0;
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 5))
        0: sep = '0;
        1: sep = '1;
        2: sep = {8{8'($urandom())}};
        default: sep = {$urandom(), $urandom()};
      endcase
      case ($urandom_range(0, 6))
        0: sl_cfg = 4'd0;
        1: sl_cfg = 4'd1;
        2: sl_cfg = 4'd8;
        3: sl_cfg = 4'd15;
        default: sl_cfg = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 4))
        2: lim = 16'd1;
        3: lim = 16'hFFFF;
        4: lim = 16'($urandom_range(1, 4));
        default: lim = 16'd0;
      endcase
      sl_used = (sl_cfg > 8) ? 8 : int'(sl_cfg);
      write_config(sep, sl_cfg, lim, $urandom_range(0, 3) == 0);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + 50;
      while (items_sent < phase_end) send_random_string(sep, sl_used);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
